/* design/assert_macros.svh */
// assertion helpers for the register access core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* design/imc_pkg.sv */
package imc_pkg;

	localparam int QueueDepth  = 4;
	localparam int QueuePtrW   = $clog2(QueueDepth);
	localparam int QueueCntW   = $clog2(QueueDepth + 1);
	localparam int ByteBits    = 8;
	localparam int RecoverPulses = 9;
	localparam logic [7:0] AckTimeoutReset = 8'd20;

	typedef enum logic [1:0] {
		CMD_NONE    = 2'd0,
		CMD_WRITE   = 2'd1,
		CMD_READ    = 2'd2,
		CMD_RECOVER = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_ADDR_NACK = 3'd1,
		ST_REG_NACK  = 3'd2,
		ST_DATA_NACK = 3'd3,
		ST_ZERO_LEN  = 3'd4
	} status_t;

	typedef struct packed {
		cmd_t       cmd;
		logic       zero_len;
		logic [6:0] device_address;
		logic [7:0] register_number;
		logic [7:0] write_data;
		logic [7:0] read_length;
		logic       sda_sample;
	} item_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       busy_res;
		logic       byte_valid;
		logic [7:0] read_byte;
		logic       read_last;
		logic       done_res;
		status_t    status;
	} res_t;

endpackage

/* design/imc_front.sv */
module imc_front import imc_pkg::*; (
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] op,
	input  logic [6:0] device_address,
	input  logic [7:0] register_number,
	input  logic [7:0] write_data,
	input  logic [7:0] read_length,
	input  logic       sda_sample,
	output logic       push_valid,
	input  logic       push_stall,
	output item_t      push_item
);

	// decode the command and flag an empty read run up front
	always_comb begin
		push_item.cmd             = cmd_t'(op);
		push_item.zero_len        = (read_length == 8'd0);
		push_item.device_address  = device_address;
		push_item.register_number = register_number;
		push_item.write_data      = write_data;
		push_item.read_length     = read_length;
		push_item.sda_sample      = sda_sample;
	end

	assign push_valid = in_valid;
	assign in_stall   = push_stall;

endmodule

/* design/imc_queue.sv */
module imc_queue import imc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_stall,
	input  item_t push_item,
	output logic  pop_valid,
	input  logic  pop_stall,
	output item_t pop_item
);

	item_t                 entries_q [QueueDepth];
	logic [QueuePtrW-1:0]  wr_ptr_q;
	logic [QueuePtrW-1:0]  rd_ptr_q;
	logic [QueueCntW-1:0]  count_q;
	logic                  push;
	logic                  pop;

	assign push_stall = (count_q == QueueCntW'(QueueDepth));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = entries_q[rd_ptr_q];
	assign push       = push_valid && !push_stall;
	assign pop        = pop_valid && !pop_stall;

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* design/imc_engine.sv */
module imc_engine import imc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] ack_timeout,
	input  logic       item_valid,
	output logic       item_stall,
	input  item_t      item,
	output logic       res_valid,
	input  logic       res_stall,
	output res_t       res
);

	typedef enum logic [4:0] {
		PH_IDLE, PH_ST_HI, PH_ST_LO, PH_TX_LOW, PH_TX_HIGH, PH_AK_LOW, PH_AK_HIGH,
		PH_AK_CHECK, PH_RB_HIGH, PH_RB_SAMPLE, PH_RA_HIGH, PH_RA_END, PH_SP_A,
		PH_SP_B, PH_SP_C, PH_RC_LOW, PH_RC_HIGH
	} phase_t;

	phase_t     phase_q, ph, ph_n;
	logic [3:0] bit_count_q, bc_n;
	logic [7:0] shift_q, sb_n;
	logic [7:0] bytes_left_q, bl_n;
	logic [7:0] ack_wait_q, aw_n;
	logic [6:0] dev_q, dev_n;
	logic [7:0] reg_q, reg_n;
	logic [7:0] wdata_q, wr_n;
	logic       scl_q, scl_n;
	logic       sda_q, sda_n;
	cmd_t       kind_q, kind_n;
	logic [1:0] stage_q, stage_n;
	status_t    code_q, code_n;
	logic       done;
	status_t    st;
	logic       bv;
	logic [7:0] rb;
	logic       rl;
	logic       fire;
	logic       res_valid_q;
	res_t       res_q;

	assign item_stall = res_valid_q && res_stall;
	assign fire       = item_valid && !item_stall;
	assign res_valid  = res_valid_q;
	assign res        = res_q;

	always_comb begin
		ph      = phase_q;
		bc_n    = bit_count_q;
		sb_n    = shift_q;
		bl_n    = bytes_left_q;
		aw_n    = ack_wait_q;
		dev_n   = dev_q;
		reg_n   = reg_q;
		wr_n    = wdata_q;
		scl_n   = scl_q;
		sda_n   = sda_q;
		kind_n  = kind_q;
		stage_n = stage_q;
		code_n  = code_q;
		done    = 1'b0;
		st      = ST_OK;
		bv      = 1'b0;
		rb      = 8'd0;
		rl      = 1'b0;

		// command launch when idle
		if (phase_q == PH_IDLE && item.cmd != CMD_NONE) begin
			if (item.cmd == CMD_READ && item.zero_len) begin
				done = 1'b1;
				st   = ST_ZERO_LEN;
			end else begin
				dev_n   = item.device_address;
				reg_n   = item.register_number;
				wr_n    = item.write_data;
				bl_n    = item.read_length;
				kind_n  = item.cmd;
				stage_n = 2'd0;
				bc_n    = 4'd0;
				code_n  = ST_OK;
				sb_n    = {item.device_address, 1'b0};
				ph      = (item.cmd == CMD_RECOVER) ? PH_RC_LOW : PH_ST_HI;
			end
		end

		ph_n = ph;
		unique case (ph)
			PH_IDLE: begin
			end
			PH_ST_HI: begin
				scl_n = 1'b1; sda_n = 1'b1;
				ph_n  = PH_ST_LO;
			end
			PH_ST_LO: begin
				scl_n = 1'b1; sda_n = 1'b0;
				bc_n  = 4'd0;
				ph_n  = PH_TX_LOW;
			end
			PH_TX_LOW: begin
				scl_n = 1'b0; sda_n = sb_n[7];
				ph_n  = PH_TX_HIGH;
			end
			PH_TX_HIGH: begin
				scl_n = 1'b1; sda_n = sb_n[7];
				sb_n  = {sb_n[6:0], 1'b0};
				bc_n  = bc_n + 4'd1;
				ph_n  = (bc_n >= 4'(ByteBits)) ? PH_AK_LOW : PH_TX_LOW;
			end
			PH_AK_LOW: begin
				scl_n = 1'b0; sda_n = 1'b1;
				aw_n  = 8'd0;
				ph_n  = PH_AK_HIGH;
			end
			PH_AK_HIGH: begin
				scl_n = 1'b1; sda_n = 1'b1;
				ph_n  = PH_AK_CHECK;
			end
			PH_AK_CHECK: begin
				if (!item.sda_sample) begin
					scl_n = 1'b0; sda_n = 1'b1;
					bc_n  = 4'd0;
					if (stage_n == 2'd0) begin
						sb_n    = reg_n;
						stage_n = 2'd1;
						ph_n    = PH_TX_LOW;
					end else if (stage_n == 2'd1) begin
						stage_n = 2'd2;
						if (kind_n == CMD_READ) begin
							sb_n = {dev_n, 1'b1};
							ph_n = PH_ST_HI;
						end else begin
							sb_n = wr_n;
							ph_n = PH_TX_LOW;
						end
					end else if (kind_n == CMD_READ) begin
						sb_n = 8'd0;
						ph_n = PH_RB_HIGH;
					end else begin
						code_n = ST_OK;
						ph_n   = PH_SP_A;
					end
				end else if (aw_n >= ack_timeout) begin
					scl_n = 1'b0; sda_n = 1'b1;
					unique case (stage_n)
						2'd0:    code_n = ST_ADDR_NACK;
						2'd1:    code_n = ST_REG_NACK;
						2'd2:    code_n = ST_DATA_NACK;
						default: code_n = ST_ZERO_LEN;
					endcase
					ph_n = PH_SP_A;
				end else begin
					aw_n  = aw_n + 8'd1;
					scl_n = 1'b1; sda_n = 1'b1;
				end
			end
			PH_RB_HIGH: begin
				scl_n = 1'b1; sda_n = 1'b1;
				ph_n  = PH_RB_SAMPLE;
			end
			PH_RB_SAMPLE: begin
				sb_n = {sb_n[6:0], item.sda_sample};
				bc_n = bc_n + 4'd1;
				if (bc_n < 4'(ByteBits)) begin
					scl_n = 1'b0; sda_n = 1'b1;
					ph_n  = PH_RB_HIGH;
				end else begin
					bv    = 1'b1;
					rb    = sb_n;
					rl    = (bl_n <= 8'd1);
					scl_n = 1'b0; sda_n = rl;
					ph_n  = PH_RA_HIGH;
				end
			end
			PH_RA_HIGH: begin
				scl_n = 1'b1;
				ph_n  = PH_RA_END;
			end
			PH_RA_END: begin
				if (bl_n != 8'd0) begin
					bl_n = bl_n - 8'd1;
				end
				if (bl_n != 8'd0) begin
					scl_n = 1'b0; sda_n = 1'b1;
					bc_n  = 4'd0;
					sb_n  = 8'd0;
					ph_n  = PH_RB_HIGH;
				end else begin
					scl_n  = 1'b0; sda_n = 1'b0;
					code_n = ST_OK;
					ph_n   = PH_SP_B;
				end
			end
			PH_SP_A: begin
				scl_n = 1'b0; sda_n = 1'b0;
				ph_n  = PH_SP_B;
			end
			PH_SP_B: begin
				scl_n = 1'b1; sda_n = 1'b0;
				ph_n  = PH_SP_C;
			end
			PH_SP_C: begin
				scl_n = 1'b1; sda_n = 1'b1;
				done  = 1'b1;
				st    = code_n;
				ph_n  = PH_IDLE;
			end
			PH_RC_LOW: begin
				scl_n = 1'b0; sda_n = 1'b1;
				ph_n  = PH_RC_HIGH;
			end
			PH_RC_HIGH: begin
				scl_n = 1'b1; sda_n = 1'b1;
				bc_n  = bc_n + 4'd1;
				if (bc_n >= 4'(RecoverPulses)) begin
					code_n = ST_OK;
					ph_n   = PH_SP_A;
				end else begin
					ph_n = PH_RC_LOW;
				end
			end
			default: begin
				scl_n = 1'b1; sda_n = 1'b1;
				ph_n  = PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			bit_count_q  <= 4'd0;
			shift_q      <= 8'd0;
			bytes_left_q <= 8'd0;
			ack_wait_q   <= 8'd0;
			dev_q        <= 7'd0;
			reg_q        <= 8'd0;
			wdata_q      <= 8'd0;
			scl_q        <= 1'b1;
			sda_q        <= 1'b1;
			kind_q       <= CMD_NONE;
			stage_q      <= 2'd0;
			code_q       <= ST_OK;
			res_valid_q  <= 1'b0;
			res_q        <= '0;
		end else begin
			if (fire) begin
				phase_q      <= ph_n;
				bit_count_q  <= bc_n;
				shift_q      <= sb_n;
				bytes_left_q <= bl_n;
				ack_wait_q   <= aw_n;
				dev_q        <= dev_n;
				reg_q        <= reg_n;
				wdata_q      <= wr_n;
				scl_q        <= scl_n;
				sda_q        <= sda_n;
				kind_q       <= kind_n;
				stage_q      <= stage_n;
				code_q       <= code_n;
				res_valid_q  <= 1'b1;
				res_q.scl_level  <= scl_n;
				res_q.sda_level  <= sda_n;
				res_q.busy_res   <= (ph_n != PH_IDLE);
				res_q.byte_valid <= bv;
				res_q.read_byte  <= rb;
				res_q.read_last  <= rl;
				res_q.done_res   <= done;
				res_q.status     <= st;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* design/i2c_master_register_access_core.sv */
// I2C master for single register writes, register run reads and bus recovery, stepped by
// timing ticks. Every accepted input transaction is one bus tick (with the sampled SDA level
// and an optional command) and yields exactly one output transaction with the SCL/SDA levels
// for the next interval, busy, any received byte and the final status. Commands arriving while
// busy are ignored; a read of length zero finishes at once with status 4. Ticks enter a
// four-entry queue and are executed by the bus sequencer one per clock, so the block sustains
// one tick per cycle when nothing stalls; each tick is queued and its result registered.
// The acknowledge timeout register may be written only while no transaction is in flight.
`include "assert_macros.svh"

module i2c_master_register_access_core import imc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] op,
	input  logic [6:0] device_address,
	input  logic [7:0] register_number,
	input  logic [7:0] write_data,
	input  logic [7:0] read_length,
	input  logic       sda_sample,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       scl_level,
	output logic       sda_level,
	output logic       busy_res,
	output logic       byte_valid,
	output logic [7:0] read_byte,
	output logic       read_last,
	output logic       done_res,
	output logic [2:0] status,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);

	logic       push_valid;
	logic       push_stall;
	item_t      push_item;
	logic       pop_valid;
	logic       pop_stall;
	item_t      pop_item;
	res_t       res;
	logic [7:0] ack_timeout_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_timeout_q <= AckTimeoutReset;
		end else if (cfg_valid && cfg_ready) begin
			ack_timeout_q <= cfg_data;
		end
	end

	imc_front u_front (
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.op              (op),
		.device_address  (device_address),
		.register_number (register_number),
		.write_data      (write_data),
		.read_length     (read_length),
		.sda_sample      (sda_sample),
		.push_valid      (push_valid),
		.push_stall      (push_stall),
		.push_item       (push_item)
	);

	imc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_stall (push_stall),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_stall  (pop_stall),
		.pop_item   (pop_item)
	);

	imc_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.ack_timeout (ack_timeout_q),
		.item_valid  (pop_valid),
		.item_stall  (pop_stall),
		.item        (pop_item),
		.res_valid   (out_valid),
		.res_stall   (out_stall),
		.res         (res)
	);

	assign scl_level  = res.scl_level;
	assign sda_level  = res.sda_level;
	assign busy_res   = res.busy_res;
	assign byte_valid = res.byte_valid;
	assign read_byte  = res.read_byte;
	assign read_last  = res.read_last;
	assign done_res   = res.done_res;
	assign status     = res.status;

	// a finished command leaves the sequencer idle
	`ASSERT_IMPLIES(a_done_idle, clk, arst_n, out_valid && done_res, !busy_res)
	// a received byte always comes mid command, ahead of its acknowledge
	`ASSERT_IMPLIES(a_byte_busy, clk, arst_n, out_valid && byte_valid, busy_res && !done_res)
	// status only accompanies done
	`ASSERT_IMPLIES(a_status_done, clk, arst_n, out_valid && status != ST_OK, done_res)
	// a received byte is followed by the acknowledge clock high tick
	`ASSERT_NEXT(a_ack_after_byte, clk, arst_n,
		out_valid && !out_stall && byte_valid && !scl_level, !out_valid || scl_level)

endmodule

/* tb/i2c_master_register_access_core_test.sv */
module i2c_master_register_access_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import imc_pkg::*;

	typedef enum logic [4:0] {
		PH_IDLE,
		PH_START_HI,
		PH_START_LO,
		PH_TX_LOW,
		PH_TX_HIGH,
		PH_ACK_LOW,
		PH_ACK_HIGH,
		PH_ACK_CHECK,
		PH_RX_HIGH,
		PH_RX_SAMPLE,
		PH_RXACK_HIGH,
		PH_RXACK_END,
		PH_STOP_A,
		PH_STOP_B,
		PH_STOP_C,
		PH_RCV_LOW,
		PH_RCV_HIGH
	} bus_phase_t;

	typedef struct packed {
		cmd_t       op;
		logic [6:0] dev;
		logic [7:0] regn;
		logic [7:0] wdata;
		logic [7:0] len;
		logic       sda;
	} tick_t;

	// one bus command and how the simulated target answers it
	typedef struct packed {
		bit         set_to;
		logic [7:0] to_val;
		cmd_t       op;
		logic [6:0] dev;
		logic [7:0] regn;
		logic [7:0] wdata;
		logic [7:0] len;
		logic [7:0] rd_byte;
		bit         rand_rd;
		int         nack_slot;
		int         ack_delay;
		bit         pester;
		bit         known;
		status_t    final_status;
	} command_t;

	localparam res_t BUS_AT_REST = '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK};

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [1:0] op;
	logic [6:0] device_address;
	logic [7:0] register_number;
	logic [7:0] write_data;
	logic [7:0] read_length;
	logic       sda_sample;
	logic       out_valid;
	logic       out_stall;
	logic       scl_level;
	logic       sda_level;
	logic       busy_res;
	logic       byte_valid;
	logic [7:0] read_byte;
	logic       read_last;
	logic       done_res;
	logic [2:0] status;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [7:0] cfg_data;

	i2c_master_register_access_core dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.op              (op),
		.device_address  (device_address),
		.register_number (register_number),
		.write_data      (write_data),
		.read_length     (read_length),
		.sda_sample      (sda_sample),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.scl_level       (scl_level),
		.sda_level       (sda_level),
		.busy_res        (busy_res),
		.byte_valid      (byte_valid),
		.read_byte       (read_byte),
		.read_last       (read_last),
		.done_res        (done_res),
		.status          (status),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data)
	);

	// bus model state
	bus_phase_t bus_ph;
	logic [3:0] bit_cnt;
	logic [7:0] shifter;
	logic [7:0] bytes_left;
	logic [7:0] wait_cnt;
	logic [6:0] lat_dev;
	logic [7:0] lat_reg;
	logic [7:0] lat_data;
	logic       scl_q;
	logic       sda_q;
	cmd_t       kind;
	logic [1:0] stage;
	status_t    code;
	logic [7:0] timeout_ticks;

	res_t bus_results_due[$];
	int   failures;
	int   sent_ticks;
	bit   send_calm;
	bit   recv_calm;
	bit   hold_off_req;

	command_t directed_commands [20] = '{
		'{0, 8'd0,   CMD_NONE,    7'h00, 8'h00, 8'h00, 8'd0,   8'h00, 0, -1, 0,  0, 1, ST_OK},
		'{0, 8'd0,   CMD_READ,    7'h7f, 8'hff, 8'hff, 8'd0,   8'h00, 0, -1, 0,  0, 1, ST_ZERO_LEN},
		'{0, 8'd0,   CMD_WRITE,   7'h00, 8'h00, 8'h00, 8'd0,   8'h00, 0, -1, 0,  0, 1, ST_OK},
		'{0, 8'd0,   CMD_WRITE,   7'h7f, 8'hff, 8'hff, 8'd255, 8'h00, 0, -1, 0,  0, 1, ST_OK},
		'{0, 8'd0,   CMD_READ,    7'h55, 8'haa, 8'h00, 8'd1,   8'hff, 0, -1, 0,  0, 1, ST_OK},
		'{0, 8'd0,   CMD_READ,    7'h7f, 8'h00, 8'h00, 8'd3,   8'h00, 0, -1, 0,  0, 1, ST_OK},
		'{0, 8'd0,   CMD_WRITE,   7'h2a, 8'h11, 8'h22, 8'd0,   8'h00, 0,  0, 0,  0, 1, ST_ADDR_NACK},
		'{0, 8'd0,   CMD_WRITE,   7'h15, 8'h33, 8'h44, 8'd0,   8'h00, 0,  1, 0,  0, 1, ST_REG_NACK},
		'{0, 8'd0,   CMD_WRITE,   7'h6b, 8'h55, 8'h66, 8'd0,   8'h00, 0,  2, 0,  0, 1, ST_DATA_NACK},
		'{0, 8'd0,   CMD_READ,    7'h3c, 8'h77, 8'h00, 8'd2,   8'h00, 0,  2, 0,  0, 1, ST_DATA_NACK},
		'{0, 8'd0,   CMD_READ,    7'h01, 8'h80, 8'h00, 8'd255, 8'h00, 0,  0, 0,  0, 1, ST_ADDR_NACK},
		'{0, 8'd0,   CMD_READ,    7'h40, 8'h01, 8'h00, 8'd128, 8'h00, 0,  1, 0,  0, 1, ST_REG_NACK},
		'{0, 8'd0,   CMD_RECOVER, 7'h00, 8'h00, 8'h00, 8'd0,   8'h00, 0, -1, 0,  0, 1, ST_OK},
		'{0, 8'd0,   CMD_WRITE,   7'h5a, 8'ha5, 8'h3c, 8'd0,   8'h00, 0, -1, 3,  1, 0, ST_OK},
		// ack arrives on the last tolerated wait, then one wait too many
		'{0, 8'd0,   CMD_READ,    7'h26, 8'hc3, 8'h00, 8'd2,   8'h00, 1, -1, 20, 1, 1, ST_OK},
		'{0, 8'd0,   CMD_WRITE,   7'h26, 8'hc3, 8'h00, 8'd2,   8'h00, 1, -1, 21, 0, 1, ST_ADDR_NACK},
		// zero timeout: first high sample fails the slot
		'{1, 8'd0,   CMD_WRITE,   7'h33, 8'h44, 8'h55, 8'd0,   8'h00, 0, -1, 1,  0, 1, ST_ADDR_NACK},
		'{0, 8'd0,   CMD_WRITE,   7'h33, 8'h44, 8'h55, 8'd0,   8'h00, 0, -1, 0,  0, 1, ST_OK},
		'{1, 8'd255, CMD_WRITE,   7'h0f, 8'hf0, 8'h0f, 8'd0,   8'h00, 0,  2, 0,  0, 1, ST_DATA_NACK},
		'{1, 8'd1,   CMD_READ,    7'h70, 8'h0e, 8'h00, 8'd2,   8'h00, 1, -1, 1,  1, 0, ST_OK}
	};

	function automatic void reset_bus_model();
		bus_ph = PH_IDLE;
		bit_cnt = '0;
		shifter = '0;
		bytes_left = '0;
		wait_cnt = '0;
		lat_dev = '0;
		lat_reg = '0;
		lat_data = '0;
		scl_q = 1'b1;
		sda_q = 1'b1;
		kind = CMD_NONE;
		stage = '0;
		code = ST_OK;
		timeout_ticks = AckTimeoutReset;
	endfunction

	function automatic void set_pins(input logic scl, input logic sda);
		scl_q = scl;
		sda_q = sda;
	endfunction

	function automatic string res_text(input res_t r);
		return {$sformatf("scl %b sda %b busy %b valid %b", r.scl_level, r.sda_level,
			r.busy_res, r.byte_valid), $sformatf(" byte %h last %b done %b status %0d",
			r.read_byte, r.read_last, r.done_res, r.status)};
	endfunction

	function automatic res_t advance_bus(input tick_t t);
		res_t r;
		r = '0;
		if (bus_ph == PH_IDLE && t.op != CMD_NONE) begin
			if (t.op == CMD_READ && t.len == 8'd0) begin
				r.done_res = 1'b1;
				r.status = ST_ZERO_LEN;
			end else begin
				lat_dev = t.dev;
				lat_reg = t.regn;
				lat_data = t.wdata;
				bytes_left = t.len;
				kind = t.op;
				stage = '0;
				bit_cnt = '0;
				code = ST_OK;
				shifter = {t.dev, 1'b0};
				bus_ph = (t.op == CMD_RECOVER) ? PH_RCV_LOW : PH_START_HI;
			end
		end
		case (bus_ph)
			PH_IDLE: ;
			PH_START_HI: begin
				set_pins(1'b1, 1'b1);
				bus_ph = PH_START_LO;
			end
			PH_START_LO: begin
				set_pins(1'b1, 1'b0);
				bit_cnt = '0;
				bus_ph = PH_TX_LOW;
			end
			PH_TX_LOW: begin
				set_pins(1'b0, shifter[7]);
				bus_ph = PH_TX_HIGH;
			end
			PH_TX_HIGH: begin
				set_pins(1'b1, shifter[7]);
				shifter = {shifter[6:0], 1'b0};
				bit_cnt++;
				bus_ph = (bit_cnt >= 4'd8) ? PH_ACK_LOW : PH_TX_LOW;
			end
			PH_ACK_LOW: begin
				set_pins(1'b0, 1'b1);
				wait_cnt = '0;
				bus_ph = PH_ACK_HIGH;
			end
			PH_ACK_HIGH: begin
				set_pins(1'b1, 1'b1);
				bus_ph = PH_ACK_CHECK;
			end
			PH_ACK_CHECK: begin
				if (t.sda == 1'b0) begin
					set_pins(1'b0, 1'b1);
					bit_cnt = '0;
					if (stage == 2'd0) begin
						shifter = lat_reg;
						stage = 2'd1;
						bus_ph = PH_TX_LOW;
					end else if (stage == 2'd1) begin
						stage = 2'd2;
						if (kind == CMD_READ) begin
							shifter = {lat_dev, 1'b1};
							bus_ph = PH_START_HI;
						end else begin
							shifter = lat_data;
							bus_ph = PH_TX_LOW;
						end
					end else if (kind == CMD_READ) begin
						shifter = '0;
						bus_ph = PH_RX_HIGH;
					end else begin
						code = ST_OK;
						bus_ph = PH_STOP_A;
					end
				end else if (wait_cnt >= timeout_ticks) begin
					set_pins(1'b0, 1'b1);
					code = status_t'({1'b0, stage} + 3'd1);
					bus_ph = PH_STOP_A;
				end else begin
					wait_cnt++;
					set_pins(1'b1, 1'b1);
				end
			end
			PH_RX_HIGH: begin
				set_pins(1'b1, 1'b1);
				bus_ph = PH_RX_SAMPLE;
			end
			PH_RX_SAMPLE: begin
				shifter = {shifter[6:0], t.sda};
				bit_cnt++;
				if (bit_cnt < 4'd8) begin
					set_pins(1'b0, 1'b1);
					bus_ph = PH_RX_HIGH;
				end else begin
					r.byte_valid = 1'b1;
					r.read_byte = shifter;
					r.read_last = (bytes_left <= 8'd1);
					set_pins(1'b0, r.read_last);
					bus_ph = PH_RXACK_HIGH;
				end
			end
			PH_RXACK_HIGH: begin
				set_pins(1'b1, sda_q);
				bus_ph = PH_RXACK_END;
			end
			PH_RXACK_END: begin
				if (bytes_left > 8'd0)
					bytes_left--;
				if (bytes_left > 8'd0) begin
					set_pins(1'b0, 1'b1);
					bit_cnt = '0;
					shifter = '0;
					bus_ph = PH_RX_HIGH;
				end else begin
					set_pins(1'b0, 1'b0);
					code = ST_OK;
					bus_ph = PH_STOP_B;
				end
			end
			PH_STOP_A: begin
				set_pins(1'b0, 1'b0);
				bus_ph = PH_STOP_B;
			end
			PH_STOP_B: begin
				set_pins(1'b1, 1'b0);
				bus_ph = PH_STOP_C;
			end
			PH_STOP_C: begin
				set_pins(1'b1, 1'b1);
				r.done_res = 1'b1;
				r.status = code;
				bus_ph = PH_IDLE;
			end
			PH_RCV_LOW: begin
				set_pins(1'b0, 1'b1);
				bus_ph = PH_RCV_HIGH;
			end
			PH_RCV_HIGH: begin
				set_pins(1'b1, 1'b1);
				bit_cnt++;
				if (bit_cnt >= 4'(RecoverPulses)) begin
					code = ST_OK;
					bus_ph = PH_STOP_A;
				end else begin
					bus_ph = PH_RCV_LOW;
				end
			end
			default: begin
				set_pins(1'b1, 1'b1);
				bus_ph = PH_IDLE;
			end
		endcase
		r.scl_level = scl_q;
		r.sda_level = sda_q;
		r.busy_res = (bus_ph != PH_IDLE);
		return r;
	endfunction

	function automatic int idle_len(input bit calm);
		int roll;
		if (calm)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	function automatic command_t random_command();
		command_t c;
		int roll;
		c = '0;
		c.nack_slot = -1;
		c.dev = 7'($urandom);
		c.regn = 8'($urandom);
		c.wdata = 8'($urandom);
		c.len = 8'($urandom);
		c.rand_rd = 1'b1;
		c.pester = ($urandom_range(0, 3) == 0);
		roll = $urandom_range(0, 99);
		if (roll < 25) begin
			c.op = CMD_NONE;
		end else if (roll < 55) begin
			c.op = CMD_READ;
			if ($urandom_range(0, 79) == 0)
				c.len = 8'($urandom_range(5, 12));
			else
				c.len = 8'($urandom_range(1, 4));
		end else if (roll < 85) begin
			c.op = CMD_WRITE;
		end else if (roll < 94) begin
			c.op = CMD_RECOVER;
		end else begin
			c.op = CMD_READ;
			c.len = 8'd0;
		end
		if ($urandom_range(0, 6) == 0)
			c.nack_slot = $urandom_range(0, 2);
		roll = $urandom_range(0, 99);
		if (roll < 70)
			c.ack_delay = 0;
		else if (roll < 95)
			c.ack_delay = $urandom_range(1, 3);
		else
			c.ack_delay = $urandom_range(0, int'(timeout_ticks) + 1);
		return c;
	endfunction

	task automatic send_tick(input tick_t t, output res_t predicted);
		int gap;
		if ($urandom_range(0, 199) == 0)
			send_calm = !send_calm;
		gap = idle_len(send_calm);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		op <= t.op;
		device_address <= t.dev;
		register_number <= t.regn;
		write_data <= t.wdata;
		read_length <= t.len;
		sda_sample <= t.sda;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predicted = advance_bus(t);
		sent_ticks++;
	endtask

	// stops sending, lets every expected tick come out, then waits in quiet
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (bus_results_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_ack_timeout(input logic [7:0] ticks);
		drain_results();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= ticks;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		timeout_ticks = ticks;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_command(input command_t c);
		tick_t      t;
		res_t       due;
		int         slot;
		int         wait_left;
		int         nbyte;
		logic [7:0] rx_byte;
		bit         first;
		if (c.set_to)
			set_ack_timeout(c.to_val);
		slot = -1;
		wait_left = 0;
		nbyte = 0;
		rx_byte = 8'h00;
		first = 1'b1;
		do begin
			t.op = CMD_NONE;
			t.dev = 7'($urandom);
			t.regn = 8'($urandom);
			t.wdata = 8'($urandom);
			t.len = 8'($urandom);
			t.sda = 1'($urandom);
			if (first) begin
				t.op = c.op;
				t.dev = c.dev;
				t.regn = c.regn;
				t.wdata = c.wdata;
				t.len = c.len;
			end else if (c.pester && $urandom_range(0, 3) == 0) begin
				t.op = cmd_t'($urandom_range(1, 3));
			end
			// the target answers acknowledge slots and read bits
			case (bus_ph)
				PH_ACK_LOW: begin
					slot++;
					wait_left = c.ack_delay;
				end
				PH_ACK_CHECK: begin
					if (slot == c.nack_slot) begin
						t.sda = 1'b1;
					end else if (wait_left > 0) begin
						t.sda = 1'b1;
						wait_left--;
					end else begin
						t.sda = 1'b0;
					end
				end
				PH_RX_SAMPLE: begin
					if (bit_cnt == 4'd0) begin
						if (c.rand_rd)
							rx_byte = 8'($urandom);
						else
							rx_byte = nbyte[0] ? ~c.rd_byte : c.rd_byte;
						nbyte++;
					end
					t.sda = rx_byte[3'(7 - int'(bit_cnt))];
				end
				default: ;
			endcase
			send_tick(t, due);
			if (c.known && bus_ph == PH_IDLE) begin
				if (c.op == CMD_NONE)
					due = BUS_AT_REST;
				else
					due.status = c.final_status;
			end
			bus_results_due.push_back(due);
			first = 1'b0;
		end while (bus_ph != PH_IDLE);
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#12ms;
		$display("simulation failed");
		$finish;
	end

	always @(posedge clk) begin
		res_t seen;
		res_t want;
		if (arst_n && out_valid && !out_stall) begin
			seen.scl_level = scl_level;
			seen.sda_level = sda_level;
			seen.busy_res = busy_res;
			seen.byte_valid = byte_valid;
			seen.read_byte = read_byte;
			seen.read_last = read_last;
			seen.done_res = done_res;
			seen.status = status_t'(status);
			if (bus_results_due.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected output transaction at %0t", $realtime);
			end else begin
				want = bus_results_due.pop_front();
				if (seen !== want) begin
					failures++;
					if (failures <= 10)
						$display("mismatch at %0t: expected %s, got %s", $realtime,
							res_text(want), res_text(seen));
				end
			end
		end
	end

	// receiver side, long hold-offs on request
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				stall_left = 80;
			end
			if (stall_left == 0) begin
				if ($urandom_range(0, 199) == 0)
					recv_calm = !recv_calm;
				stall_left = idle_len(recv_calm);
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		logic [7:0] phase_timeout;
		int         budget;
		bit         paused;
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = CMD_NONE;
		device_address = '0;
		register_number = '0;
		write_data = '0;
		read_length = '0;
		sda_sample = 1'b1;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		failures = 0;
		sent_ticks = 0;
		send_calm = 1'b0;
		recv_calm = 1'b0;
		hold_off_req = 1'b0;
		reset_bus_model();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_commands[i])
			run_command(directed_commands[i]);

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: phase_timeout = AckTimeoutReset;
				1: phase_timeout = 8'd255;
				2: phase_timeout = 8'd1;
				5: phase_timeout = 8'd2;
				default: phase_timeout = 8'($urandom_range(1, 255));
			endcase
			set_ack_timeout(phase_timeout);
			hold_off_req = 1'b1;
			budget = sent_ticks + 20;
			paused = 1'b0;
			while (sent_ticks < budget) begin
				if (!paused && sent_ticks >= budget - 10) begin
					drain_results();
					paused = 1'b1;
				end
				run_command(random_command());
			end
		end

		drain_results();
		repeat (10) @(posedge clk);
		if (failures == 0 && bus_results_due.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

/* files.f */
+incdir+design
design/imc_pkg.sv
design/imc_front.sv
design/imc_queue.sv
design/imc_engine.sv
design/i2c_master_register_access_core.sv
tb/i2c_master_register_access_core_test.sv
